### sv/spd_pkg.sv
// ----------------------------------------------------------------------------
// Serial packet deframer package
// Shared types, codes and widths for the deframer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;

	// Packet parse position
	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_SEQ     = 3'd1,
		PH_SIZE_HI = 3'd2,
		PH_SIZE_LO = 3'd3,
		PH_TOKEN   = 3'd4,
		PH_DATA    = 3'd5,
		PH_CHECK   = 3'd6
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_START = 3'd1;
	localparam logic [2:0] ERR_SEQ   = 3'd2;
	localparam logic [2:0] ERR_SIZE  = 3'd3;
	localparam logic [2:0] ERR_TOKEN = 3'd4;
	localparam logic [2:0] ERR_SUM   = 3'd5;

	// Sequence handling modes
	localparam logic [1:0] SEQ_IGNORE = 2'd0;
	localparam logic [1:0] SEQ_ECHO   = 2'd1;
	localparam logic [1:0] SEQ_TEST   = 2'd2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SEQ_MODE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_LENGTH = 2'd1;
	localparam logic [IDX_W-1:0] REG_START_BYTE = 2'd2;
	localparam logic [IDX_W-1:0] REG_TOKEN_BYTE = 2'd3;

	// Reset values of the configuration registers
	localparam logic [1:0]  RST_SEQ_MODE   = SEQ_TEST;
	localparam logic [15:0] RST_MAX_LENGTH = 16'd275;
	localparam logic [7:0]  RST_START_BYTE = 8'd27;
	localparam logic [7:0]  RST_TOKEN_BYTE = 8'd14;

endpackage : spd_pkg

`default_nettype wire

### sv/serial_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// Serial packet deframer
// Checks the framing of received packets byte by byte and reports payload
// bytes, accepted packets and protocol errors.
// ----------------------------------------------------------------------------
//
// Use:
//   Input channel (in_valid / in_ready / rx_byte) carries one received byte
//   per item. Output channel (out_valid / out_ready) carries zero or one
//   result item per input byte: a payload byte, a packet-accepted status with
//   its length, or an error with its code. Header bytes that pass their
//   checks give no result.
//   The configuration port (cfg_we / cfg_index / cfg_data) writes seq_mode,
//   max_length, start_byte and token_byte; write only while the block is idle.
// Timing:
//   An accepted byte waits in the input register and is parsed into the result
//   register when the parse stage steps. One byte per cycle is sustained while
//   the result channel is not stalled; the single parse stage between the input
//   register and the result register sets that figure.
// Reset:
//   arst_n clears both stages, returns the parser to waiting for a start
//   byte and loads the registers with their default values.
// Stall:
//   While a result waits, the input register still holds one further byte;
//   in_ready drops only once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_packet_deframer_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	// input byte channel
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [spd_pkg::BYTE_W-1:0]   rx_byte,
	// result channel
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [1:0]                   kind,
	output logic [spd_pkg::BYTE_W-1:0]   payload_byte,
	output logic [2:0]                   error_code,
	output logic [spd_pkg::LEN_W-1:0]    packet_length,
	// configuration write port
	input  wire                          cfg_we,
	input  wire  [spd_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [spd_pkg::CFG_W-1:0]    cfg_data
);
	import spd_pkg::*;

	// configuration registers
	logic [1:0] seq_mode_q;
	len_t       max_length_q;
	byte_t      start_byte_q;
	byte_t      token_byte_q;

	// input stage
	logic  valid_s1;
	byte_t byte_s1;

	// parser state
	phase_t phase_q, phase_d;
	byte_t  xor_q, xor_d;
	byte_t  size_high_q, size_high_d;
	len_t   exp_len_q, exp_len_d;
	len_t   seen_q, seen_d;
	byte_t  seq_q, seq_d;

	// result of the current byte
	logic       res_valid;
	logic [1:0] res_kind;
	byte_t      res_payload;
	logic [2:0] res_code;
	len_t       res_len;

	logic  step;
	len_t  seen_inc;
	len_t  size_word;
	logic  size_bad;
	logic  seq_bad;

	// Advance the parse stage when the result register is free or draining.
	assign step     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	assign seen_inc  = seen_q + len_t'(1);
	assign size_word = {size_high_q, byte_s1};
	assign size_bad  = size_word > max_length_q;
	assign seq_bad   = (seq_mode_q == SEQ_TEST) && (byte_s1 != seq_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mode_q   <= RST_SEQ_MODE;
			max_length_q <= RST_MAX_LENGTH;
			start_byte_q <= RST_START_BYTE;
			token_byte_q <= RST_TOKEN_BYTE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEQ_MODE:   seq_mode_q   <= cfg_data[1:0];
				REG_MAX_LENGTH: max_length_q <= cfg_data[LEN_W-1:0];
				REG_START_BYTE: start_byte_q <= cfg_data[BYTE_W-1:0];
				REG_TOKEN_BYTE: token_byte_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: hold the byte until the parse stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT:    phase_d = (byte_s1 == start_byte_q) ? PH_SEQ : PH_WAIT;
			PH_SEQ:     phase_d = seq_bad ? PH_WAIT : PH_SIZE_HI;
			PH_SIZE_HI: phase_d = PH_SIZE_LO;
			PH_SIZE_LO: phase_d = size_bad ? PH_WAIT : PH_TOKEN;
			PH_TOKEN: begin
				if (byte_s1 != token_byte_q) begin
					phase_d = PH_WAIT;
				end else begin
					phase_d = (exp_len_q == '0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA:    phase_d = (seen_inc >= exp_len_q) ? PH_CHECK : PH_DATA;
			PH_CHECK:   phase_d = PH_WAIT;
			default:    phase_d = PH_WAIT;
		endcase
	end

	// datapath updates and result of the current byte
	always_comb begin
		xor_d       = xor_q;
		size_high_d = size_high_q;
		exp_len_d   = exp_len_q;
		seen_d      = seen_q;
		seq_d       = seq_q;
		res_valid   = 1'b0;
		res_kind    = KIND_DATA;
		res_payload = '0;
		res_code    = ERR_NONE;
		res_len     = '0;
		unique case (phase_q)
			PH_WAIT: begin
				if (byte_s1 == start_byte_q) begin
					xor_d  = byte_s1;
					seen_d = '0;
				end else begin
					res_valid = 1'b1;
					res_kind  = KIND_ERR;
					res_code  = ERR_START;
					xor_d     = '0;
					seen_d    = '0;
				end
			end
			PH_SEQ: begin
				if (seq_bad) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERR;
					res_code  = ERR_SEQ;
					xor_d     = '0;
					seen_d    = '0;
				end else begin
					xor_d = xor_q ^ byte_s1;
					if (seq_mode_q == SEQ_ECHO) begin
						seq_d = byte_s1;
					end else if (seq_mode_q == SEQ_TEST) begin
						seq_d = seq_q + byte_t'(1);
					end
				end
			end
			PH_SIZE_HI: begin
				size_high_d = byte_s1;
				xor_d       = xor_q ^ byte_s1;
			end
			PH_SIZE_LO: begin
				exp_len_d = size_word;
				if (size_bad) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERR;
					res_code  = ERR_SIZE;
					xor_d     = '0;
					seen_d    = '0;
				end else begin
					xor_d = xor_q ^ byte_s1;
				end
			end
			PH_TOKEN: begin
				if (byte_s1 != token_byte_q) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERR;
					res_code  = ERR_TOKEN;
					xor_d     = '0;
				end else begin
					xor_d = xor_q ^ byte_s1;
				end
				seen_d = '0;
			end
			PH_DATA: begin
				xor_d       = xor_q ^ byte_s1;
				seen_d      = seen_inc;
				res_valid   = 1'b1;
				res_kind    = KIND_DATA;
				res_payload = byte_s1;
			end
			PH_CHECK: begin
				res_valid = 1'b1;
				if (byte_s1 != xor_q) begin
					res_kind = KIND_ERR;
					res_code = ERR_SUM;
				end else begin
					res_kind = KIND_OK;
					res_len  = exp_len_q;
				end
				xor_d  = '0;
				seen_d = '0;
			end
			default: begin
				xor_d  = '0;
				seen_d = '0;
			end
		endcase
	end

	// parser state: advance only when the stage steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			xor_q       <= '0;
			size_high_q <= '0;
			exp_len_q   <= '0;
			seen_q      <= '0;
			seq_q       <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			xor_q       <= xor_d;
			size_high_q <= size_high_d;
			exp_len_q   <= exp_len_d;
			seen_q      <= seen_d;
			seq_q       <= seq_d;
		end
	end

	// result register: drop the old result once taken, load a new one on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			kind          <= res_kind;
			payload_byte  <= res_payload;
			error_code    <= res_code;
			packet_length <= res_len;
		end
	end

endmodule : serial_packet_deframer_unit

`default_nettype wire

### sv/spd_checker.sv
// ----------------------------------------------------------------------------
// Serial packet deframer checker
// Port-level properties of the deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [1:0]                  kind,
	input wire [spd_pkg::BYTE_W-1:0]  payload_byte,
	input wire [2:0]                  error_code,
	input wire [spd_pkg::LEN_W-1:0]   packet_length
);
	import spd_pkg::*;

	// a stalled result holds its kind, payload, code and length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
			$stable(payload_byte) && $stable(error_code) && $stable(packet_length))
		else $error("result changed while stalled");

	// a payload byte carries no code and no length
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> error_code == ERR_NONE && packet_length == '0)
		else $error("payload item carries status fields");

	// an accepted packet has no code and no payload byte
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_OK |-> error_code == ERR_NONE && payload_byte == '0)
		else $error("accept item carries stray fields");

	// an error names a cause and nothing else
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERR |-> error_code != ERR_NONE &&
			payload_byte == '0 && packet_length == '0)
		else $error("malformed error item");

	// only the three defined kinds appear
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_DATA || kind == KIND_OK || kind == KIND_ERR)
		else $error("undefined result kind");

endmodule : spd_checker

bind serial_packet_deframer_unit spd_checker u_spd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.payload_byte  (payload_byte),
	.error_code    (error_code),
	.packet_length (packet_length)
);

`default_nettype wire
